>>> sv/tilt_pkg.sv
// Shared constants, types and the arctangent table for the tilt angle pipeline.
// No dependencies; every other file refers to it by scoped names.
package tilt_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int MAX_STEPS         = 24;
  localparam int ITERS = (CORDIC_ITERATIONS < MAX_STEPS) ? CORDIC_ITERATIONS : MAX_STEPS;

  localparam int ACC_W   = 16;  // raw sample field
  localparam int GUARD   = 14;  // operand scale 2^14
  localparam int SQ_W    = 32;  // y*y + z*z
  localparam int ROOT_W  = 30;  // floor(sqrt(sq * 2^28))
  localparam int REM_W   = 34;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SIDE_W  = 3 * ACC_W;
  localparam int CW      = 34;  // CORDIC x/y width
  localparam int ZW      = 28;  // angle accumulator, degrees*65536
  localparam int OFS_W   = 17;
  localparam int ANG_W   = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_BIAS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_BIAS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;  // no register behind it

  localparam logic signed [ZW-1:0]    DEG180     = ZW'(180 * 65536);
  localparam logic signed [ANG_W-1:0] PITCH_LIM  = ANG_W'(46080);
  localparam logic signed [ANG_W-1:0] ROLL_LIM   = ANG_W'(23040);

  typedef logic signed [CW-1:0]  cword_t;
  typedef logic signed [ZW-1:0]  zacc_t;

  // atan(2^-i) in degrees*65536, rounded to nearest
  function automatic zacc_t atan_deg16(input int i);
    zacc_t r;
    case (i)
      0:  r = ZW'(2949120);
      1:  r = ZW'(1740967);
      2:  r = ZW'(919879);
      3:  r = ZW'(466945);
      4:  r = ZW'(234379);
      5:  r = ZW'(117304);
      6:  r = ZW'(58666);
      7:  r = ZW'(29335);
      8:  r = ZW'(14668);
      9:  r = ZW'(7334);
      10: r = ZW'(3667);
      11: r = ZW'(1833);
      12: r = ZW'(917);
      13: r = ZW'(458);
      14: r = ZW'(229);
      15: r = ZW'(115);
      16: r = ZW'(57);
      17: r = ZW'(29);
      18: r = ZW'(14);
      19: r = ZW'(7);
      20: r = ZW'(4);
      21: r = ZW'(2);
      22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/tilt_if.sv
// Channel interfaces: sample input, angle output and register write port.
// Depends on tilt_pkg for field widths.
interface tilt_sample_if;
  logic valid;
  logic ready;
  logic signed [tilt_pkg::ACC_W-1:0] accel_x;
  logic signed [tilt_pkg::ACC_W-1:0] accel_y;
  logic signed [tilt_pkg::ACC_W-1:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tilt_angle_if;
  logic valid;
  logic ready;
  logic signed [tilt_pkg::ANG_W-1:0] pitch_angle;
  logic signed [tilt_pkg::ANG_W-1:0] roll_angle;
  modport source (output valid, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, pitch_angle, roll_angle, output ready);
endinterface

interface tilt_cfg_if;
  logic valid;
  logic ready;
  logic [tilt_pkg::CFG_IDX_W-1:0] index;
  logic [tilt_pkg::OFS_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/tilt_isqrt.sv
// Pipelined integer square root, one root bit per stage, with side data carried along.
// Depends on tilt_pkg.
module tilt_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tilt_pkg::SQ_W-1:0]     in_sq,
  input  logic [tilt_pkg::SIDE_W-1:0]   in_side,
  output logic                          out_valid,
  output logic [tilt_pkg::ROOT_W-1:0]   out_root,
  output logic [tilt_pkg::SIDE_W-1:0]   out_side
);

  localparam int N = tilt_pkg::SQRT_STEPS;

  logic                          vld  [N];
  logic [tilt_pkg::REM_W-1:0]    rem  [N];
  logic [tilt_pkg::ROOT_W-1:0]   root [N];
  logic [tilt_pkg::SQ_W-1:0]     rad  [N];
  logic [tilt_pkg::SIDE_W-1:0]   side [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                        v_in;
    logic [tilt_pkg::REM_W-1:0]  rem_in;
    logic [tilt_pkg::ROOT_W-1:0] root_in;
    logic [tilt_pkg::SQ_W-1:0]   rad_in;
    logic [tilt_pkg::SIDE_W-1:0] side_in;
    logic [tilt_pkg::REM_W-1:0]  rem_t;
    logic [tilt_pkg::REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_sq;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[k-1];
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
      assign rad_in  = rad[k-1];
      assign side_in = side[k-1];
    end

    // radicand is sq * 2^28: its pairs come from sq first, then zeros
    assign rem_t = {rem_in[tilt_pkg::REM_W-3:0], rad_in[tilt_pkg::SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_t >= trial) begin
          rem[k]  <= rem_t - trial;
          root[k] <= {root_in[tilt_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem[k]  <= rem_t;
          root[k] <= {root_in[tilt_pkg::ROOT_W-2:0], 1'b0};
        end
        rad[k]  <= {rad_in[tilt_pkg::SQ_W-3:0], 2'b00};
        side[k] <= side_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_root  = root[N-1];
  assign out_side  = side[N-1];

endmodule

>>> sv/tilt_cordic.sv
// Pipelined CORDIC vectoring: atan2(num, den) in degrees*65536, one iteration per stage.
// Depends on tilt_pkg for widths and the arctangent table.
module tilt_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  tilt_pkg::cword_t den,
  input  tilt_pkg::cword_t num,
  output logic             out_valid,
  output tilt_pkg::zacc_t  angle
);

  localparam int N = tilt_pkg::ITERS;

  logic             vld  [N+1];
  tilt_pkg::cword_t xs   [N+1];
  tilt_pkg::cword_t ys   [N+1];
  tilt_pkg::zacc_t  zs   [N+1];
  logic             zero [N+1];
  logic             zneg [N+1];

  // prep stage: fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (num == '0);
      zneg[0] <= den[tilt_pkg::CW-1];
      if (den[tilt_pkg::CW-1]) begin
        xs[0] <= -den;
        ys[0] <= -num;
        zs[0] <= num[tilt_pkg::CW-1] ? -tilt_pkg::DEG180 : tilt_pkg::DEG180;
      end else begin
        xs[0] <= den;
        ys[0] <= num;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    tilt_pkg::cword_t dx;
    tilt_pkg::cword_t dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][tilt_pkg::CW-1]) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + tilt_pkg::atan_deg16(i);
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - tilt_pkg::atan_deg16(i);
        end
        zero[i+1] <= zero[i];
        zneg[i+1] <= zneg[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign angle = zero[N] ? (zneg[N] ? tilt_pkg::DEG180 : '0) : zs[N];

endmodule

>>> sv/accel_tilt_angles.sv
// Top level: pitch and roll from a raw accelerometer sample, minus calibration offsets.
// Depends on tilt_pkg, tilt_if, tilt_isqrt and tilt_cordic.
//
//   port     dir    beat contents
//   sample   sink   accel_x, accel_y, accel_z (16-bit signed counts)
//   angle    source pitch_angle, roll_angle (18-bit signed, degrees*256)
//   cfg      sink   index, data (offset registers; always ready)
//
// One sample enters per cycle while the output is not stalled; the pipeline is:
// input squares, sum, 30 square-root stages, CORDIC prep plus one stage per
// iteration, and the output register. The square-root pipeline is its longest part.
// rst is synchronous and clears valid bits and both offsets.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module accel_tilt_angles (
  input  logic clk,
  input  logic rst,
  tilt_sample_if.sink  sample,
  tilt_angle_if.source angle,
  tilt_cfg_if.sink     cfg
);

  logic en;

  logic signed [tilt_pkg::OFS_W-1:0] pitch_bias;
  logic signed [tilt_pkg::OFS_W-1:0] roll_bias;

  // input stage
  logic                              a_valid;
  logic [tilt_pkg::SQ_W-2:0]         a_yy;
  logic [tilt_pkg::SQ_W-2:0]         a_zz;
  logic [tilt_pkg::SIDE_W-1:0]       a_side;
  // sum stage
  logic                              b_valid;
  logic [tilt_pkg::SQ_W-1:0]         b_sq;
  logic [tilt_pkg::SIDE_W-1:0]       b_side;

  logic                              s_valid;
  logic [tilt_pkg::ROOT_W-1:0]       s_root;
  logic [tilt_pkg::SIDE_W-1:0]       s_side;

  logic signed [tilt_pkg::ACC_W-1:0] sx, sy, sz;
  tilt_pkg::cword_t p_den, p_num, r_den, r_num;
  logic             p_valid, r_valid;
  tilt_pkg::zacc_t  p_z, r_z;

  logic signed [tilt_pkg::ANG_W-1:0] p_q8, r_q8;
  logic                              o_valid;
  logic signed [tilt_pkg::ANG_W-1:0] o_pitch, o_roll;

  assign en           = !o_valid || angle.ready;
  assign sample.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_bias <= '0;
      roll_bias  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        tilt_pkg::REG_PITCH_BIAS: pitch_bias <= cfg.data;
        tilt_pkg::REG_ROLL_BIAS:  roll_bias  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sample.valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_yy   <= (tilt_pkg::SQ_W-1)'($unsigned(tilt_pkg::SQ_W'(sample.accel_y)
                                             * tilt_pkg::SQ_W'(sample.accel_y)));
      a_zz   <= (tilt_pkg::SQ_W-1)'($unsigned(tilt_pkg::SQ_W'(sample.accel_z)
                                             * tilt_pkg::SQ_W'(sample.accel_z)));
      a_side <= {sample.accel_x, sample.accel_y, sample.accel_z};
      b_sq   <= {1'b0, a_yy} + {1'b0, a_zz};
      b_side <= a_side;
    end
  end

  tilt_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b_valid),
    .in_sq    (b_sq),
    .in_side  (b_side),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_side (s_side)
  );

  assign sx = s_side[3*tilt_pkg::ACC_W-1 -: tilt_pkg::ACC_W];
  assign sy = s_side[2*tilt_pkg::ACC_W-1 -: tilt_pkg::ACC_W];
  assign sz = s_side[tilt_pkg::ACC_W-1:0];

  localparam int EXT = tilt_pkg::CW - tilt_pkg::ACC_W - tilt_pkg::GUARD;

  assign p_den = {{EXT{sz[tilt_pkg::ACC_W-1]}}, sz, {tilt_pkg::GUARD{1'b0}}};
  assign p_num = {{EXT{sy[tilt_pkg::ACC_W-1]}}, sy, {tilt_pkg::GUARD{1'b0}}};
  assign r_den = {{(tilt_pkg::CW - tilt_pkg::ROOT_W){1'b0}}, s_root};
  assign r_num = -{{EXT{sx[tilt_pkg::ACC_W-1]}}, sx, {tilt_pkg::GUARD{1'b0}}};

  tilt_cordic u_pitch (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid),
    .den(p_den), .num(p_num), .out_valid(p_valid), .angle(p_z)
  );

  tilt_cordic u_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid),
    .den(r_den), .num(r_num), .out_valid(r_valid), .angle(r_z)
  );

  // round half up to degrees*256, then clamp the CORDIC residue
  function automatic logic signed [tilt_pkg::ANG_W-1:0] to_q8(
    input tilt_pkg::zacc_t z, input logic signed [tilt_pkg::ANG_W-1:0] lim);
    tilt_pkg::zacc_t r;
    tilt_pkg::zacc_t q;
    tilt_pkg::zacc_t l;
    r = z + tilt_pkg::zacc_t'(128);
    q = r >>> 8;
    l = tilt_pkg::ZW'(lim);
    if (q > l) q = l;
    if (q < -l) q = -l;
    return q[tilt_pkg::ANG_W-1:0];
  endfunction

  assign p_q8 = to_q8(p_z, tilt_pkg::PITCH_LIM);
  assign r_q8 = to_q8(r_z, tilt_pkg::ROLL_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_pitch <= p_q8 - {pitch_bias[tilt_pkg::OFS_W-1], pitch_bias};
      o_roll  <= r_q8 - {roll_bias[tilt_pkg::OFS_W-1], roll_bias};
    end
  end

  assign angle.valid       = o_valid;
  assign angle.pitch_angle = o_pitch;
  assign angle.roll_angle  = o_roll;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    p_valid == r_valid) else $error("pitch and roll lanes out of step");

  a_roll_clamped: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (r_q8 <= tilt_pkg::ROLL_LIM) && (r_q8 >= -tilt_pkg::ROLL_LIM))
    else $error("roll outside clamp range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(p_valid) && (!p_valid || $stable(p_z)))
    else $error("pipeline moved during stall");

endmodule

>>> tb/tb_accel_tilt_angles.sv
// Testbench for accel_tilt_angles: directed table plus random samples, checked
// against a behavioral predictor of pitch/roll CORDIC angles minus offsets.
// Depends on tilt_pkg, the channel interfaces and the accel_tilt_angles RTL.
`timescale 1ns / 1ps

module tb_accel_tilt_angles;

  localparam int LATENCY   = tilt_pkg::ITERS + 34;
  localparam int MAX_CYCLES = 400000;
  localparam int N_RANDOM  = 1150;

  typedef struct packed {
    logic signed [tilt_pkg::ANG_W-1:0] pitch;
    logic signed [tilt_pkg::ANG_W-1:0] roll;
  } tilt_t;

  typedef struct {
    logic signed [tilt_pkg::ACC_W-1:0] x, y, z;
    bit                                known;
    tilt_t                             ang;
  } row_t;

  logic clk;
  logic rst;
  tilt_sample_if sample ();
  tilt_angle_if  angle ();
  tilt_cfg_if    cfg ();

  accel_tilt_angles dut (
    .clk   (clk),
    .rst   (rst),
    .sample(sample.sink),
    .angle (angle.sink),
    .cfg   (cfg.sink)
  );

  logic signed [tilt_pkg::OFS_W-1:0] pitch_ofs, roll_ofs;
  tilt_t   angles_due[$];
  int      mismatches;
  longint  cycles;
  int      stall_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // integer square root of a 64-bit value
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // atan2(num, den) in degrees*65536, CORDIC vectoring
  function automatic longint cordic_atan2(longint den, longint num);
    longint cx, cy, cz, dx, dy;
    longint half;
    half = 180 * 65536;
    cx = den;
    cy = num;
    cz = 0;
    if (num == 0) return (den < 0) ? half : 0;
    if (cx < 0) begin
      cz = (num >= 0) ? half : -half;
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < tilt_pkg::ITERS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        cz += longint'(tilt_pkg::atan_deg16(i));
      end else begin
        cx -= dx;
        cy += dy;
        cz -= longint'(tilt_pkg::atan_deg16(i));
      end
    end
    return cz;
  endfunction

  function automatic longint deg_q8(longint zv, longint lim);
    longint a;
    a = (zv + 128) >>> 8;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic tilt_t predict_tilt(logic signed [tilt_pkg::ACC_W-1:0] x,
                                         logic signed [tilt_pkg::ACC_W-1:0] y,
                                         logic signed [tilt_pkg::ACC_W-1:0] z);
    longint lx, ly, lz, mag, p, r;
    tilt_t t;
    lx = x;
    ly = y;
    lz = z;
    mag = longint'(root64(longint'(ly * ly + lz * lz) << 28));
    p = deg_q8(cordic_atan2(lz <<< 14, ly <<< 14), 46080);
    r = deg_q8(cordic_atan2(mag, (-lx) <<< 14), 23040);
    t.pitch = tilt_pkg::ANG_W'(p - longint'(pitch_ofs));
    t.roll  = tilt_pkg::ANG_W'(r - longint'(roll_ofs));
    return t;
  endfunction

  // receiver: stall pattern depends on the current mode
  always @(posedge clk) begin
    if (rst) begin
      angle.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       angle.ready <= 1'b1;
        1:       angle.ready <= ($urandom_range(0, 3) != 0);
        default: angle.ready <= ((cycles % 11) < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    tilt_t got, want;
    if (!rst) begin
      cycles <= cycles + 1;
      if (angle.valid && angle.ready) begin
        got.pitch = angle.pitch_angle;
        got.roll  = angle.roll_angle;
        if (angles_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: pitch %0d roll %0d",
                                         got.pitch, got.roll);
        end else begin
          want = angles_due.pop_front();
          if (got.pitch !== want.pitch || got.roll !== want.roll) begin
            mismatches++;
            if (mismatches <= 10)
              $display("angle mismatch: exp pitch %0d roll %0d, got pitch %0d roll %0d",
                       want.pitch, want.roll, got.pitch, got.roll);
          end
        end
      end
      if (cycles > MAX_CYCLES) begin
        $display("tb_accel_tilt_angles: done, errors");
        $finish;
      end
    end
  end

  // valid stays high after the beat; the caller drops it
  task automatic write_reg(logic [tilt_pkg::CFG_IDX_W-1:0] idx,
                           logic [tilt_pkg::OFS_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == tilt_pkg::REG_PITCH_BIAS) pitch_ofs = val;
    else if (idx == tilt_pkg::REG_ROLL_BIAS) roll_ofs = val;
  endtask

  // send one sample; valid stays high so beats can follow back to back
  task automatic send_sample(row_t rw);
    sample.valid   <= 1'b1;
    sample.accel_x <= rw.x;
    sample.accel_y <= rw.y;
    sample.accel_z <= rw.z;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    angles_due.push_back(rw.known ? rw.ang : predict_tilt(rw.x, rw.y, rw.z));
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_burst(int n);
    row_t rw;
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) begin
        rw.known = 1'b0;
        case ($urandom_range(0, 3))
          0: begin  // gravity-sized vectors, near level
            rw.x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            rw.y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            rw.z = 16'sd16384 - $signed(16'($urandom_range(0, 4000)));
          end
          1: begin  // small values near the origin
            rw.x = $signed(16'($urandom_range(0, 6))) - 16'sd3;
            rw.y = $signed(16'($urandom_range(0, 6))) - 16'sd3;
            rw.z = $signed(16'($urandom_range(0, 6))) - 16'sd3;
          end
          default: begin
            rw.x = 16'($urandom);
            rw.y = 16'($urandom);
            rw.z = 16'($urandom);
          end
        endcase
        send_sample(rw);
      end
      left -= burst;
      if ($urandom_range(0, 2) != 0) begin
        sample.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    row_t dir[$];
    row_t rw;
    tilt_t zero_ang;
    logic signed [tilt_pkg::OFS_W-1:0] ofs_set[5];
    rst = 1'b1;
    cycles = 0;
    mismatches = 0;
    stall_mode = 0;
    pitch_ofs = '0;
    roll_ofs = '0;
    sample.valid = 1'b0;
    sample.accel_x = '0;
    sample.accel_y = '0;
    sample.accel_z = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; all-zero gives exact zero angles with reset offsets
    zero_ang = '0;
    dir.push_back('{0, 0, 0, 1'b1, zero_ang});
    dir.push_back('{0, 0, 16384, 1'b1, zero_ang});
    dir.push_back('{0, 0, -16384, 1'b1, tilt_t'{18'sd46080, 18'sd0}});
    dir.push_back('{0, 0, -32768, 1'b0, zero_ang});
    dir.push_back('{32767, 32767, 32767, 1'b0, zero_ang});
    dir.push_back('{-32768, -32768, -32768, 1'b0, zero_ang});
    dir.push_back('{-32768, 0, 0, 1'b0, zero_ang});
    dir.push_back('{32767, 0, 0, 1'b0, zero_ang});
    dir.push_back('{0, 32767, 0, 1'b0, zero_ang});
    dir.push_back('{0, -32768, 0, 1'b0, zero_ang});
    dir.push_back('{0, 100, -16384, 1'b0, zero_ang});
    dir.push_back('{0, -100, -16384, 1'b0, zero_ang});
    dir.push_back('{1, -1, -32768, 1'b0, zero_ang});
    dir.push_back('{-1, 1, 1, 1'b0, zero_ang});
    dir.push_back('{16384, 16384, 0, 1'b0, zero_ang});
    dir.push_back('{-21846, 21845, -21846, 1'b0, zero_ang});
    foreach (dir[i]) send_sample(dir[i]);
    drain();

    // pressure: wait for every angle, then sweep offsets incl. extremes
    ofs_set = '{17'sd0, 17'sd46080, -17'sd46080, -17'sd65536, 17'sd65535};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(tilt_pkg::REG_PITCH_BIAS, ofs_set[ph]);
      write_reg(tilt_pkg::REG_ROLL_BIAS, ofs_set[4 - ph]);
      if (ph == 2) write_reg(tilt_pkg::REG_SPARE, 17'h1ABCD);  // ignored
      cfg.valid <= 1'b0;
      stall_mode = ph % 3;
      random_burst(N_RANDOM / 5);
      drain();
    end
    write_reg(tilt_pkg::REG_PITCH_BIAS, 17'($urandom));
    write_reg(tilt_pkg::REG_ROLL_BIAS, 17'($urandom));
    cfg.valid <= 1'b0;
    stall_mode = 1;
    random_burst(30);
    drain();

    if (mismatches == 0) begin
      $display("tb_accel_tilt_angles: done, clean");
    end else begin
      $display("tb_accel_tilt_angles: done, errors");
    end
    $finish;
  end

endmodule
